/* rtl/dtq_pkg.sv */
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and constants of the delta-list timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int ID_W    = 8;
  localparam int DELAY_W = 32;
  localparam int UNITS_W = 32;

  // stream packing
  localparam int IN_TDATA_W   = 72;  // timer_id, delay, units
  localparam int OUT_TDATA_W  = 8;   // fired_id
  localparam int OUT_TUSER_W  = 2;   // fired_valid, full_error

  localparam logic OP_APPEND  = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_LOAD,
    ST_CHECK,
    ST_FIRE,
    ST_FLUSH
  } state_t;

  typedef enum logic [0:0] {
    OUT_APPEND,
    OUT_FLUSH
  } out_kind_t;

  typedef struct packed {
    logic      load_in;   // take the request from the input channel
    logic      do_reduce; // head delay -= units
    logic      do_sub;    // units -= head delay
    logic      do_fire;   // pop head into pending slot, emit old pending
    logic      out_load;  // load a final result into the output register
    out_kind_t out_kind;
  } dtq_cmd_t;

  typedef struct packed {
    logic in_op;
    logic slot_free;
    logic pend;
    logic count_zero;
    logic units_zero;
    logic rd_dly_zero;
    logic units_lt;
  } dtq_stat_t;

endpackage

/* rtl/dtq_ctrl.sv */
// ----------------------------------------------------------------------------
// dtq_ctrl
// Sequencer of the timer queue: accepts requests and steps through the
// advance loop one head entry at a time.
// ----------------------------------------------------------------------------
module dtq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  dtq_pkg::dtq_stat_t stat,
  output dtq_pkg::dtq_cmd_t  cmd
);

  dtq_pkg::state_t state_r, state_nxt;
  logic            chain_r, chain_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dtq_pkg::ST_IDLE;
      chain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chain_r <= chain_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    chain_nxt     = chain_r;
    in_tready     = 1'b0;
    cmd           = '0;
    cmd.out_kind  = dtq_pkg::OUT_APPEND;
    unique case (state_r)
      dtq_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          chain_nxt   = 1'b0;
          state_nxt   = (stat.in_op == dtq_pkg::OP_APPEND) ? dtq_pkg::ST_APPEND
                                                            : dtq_pkg::ST_LOAD;
        end
      end
      dtq_pkg::ST_APPEND: begin
        if (stat.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = dtq_pkg::OUT_APPEND;
          state_nxt    = dtq_pkg::ST_IDLE;
        end
      end
      // wait for the registered read of the head entry
      dtq_pkg::ST_LOAD: begin
        state_nxt = dtq_pkg::ST_CHECK;
      end
      dtq_pkg::ST_CHECK: begin
        if (stat.count_zero) begin
          state_nxt = dtq_pkg::ST_FLUSH;
        end else if (chain_r && stat.rd_dly_zero) begin
          // zero-delay followers fire even when the units are used up
          state_nxt = dtq_pkg::ST_FIRE;
        end else if (stat.units_zero) begin
          state_nxt = dtq_pkg::ST_FLUSH;
        end else if (stat.units_lt) begin
          cmd.do_reduce = 1'b1;
          state_nxt     = dtq_pkg::ST_FLUSH;
        end else begin
          cmd.do_sub = 1'b1;
          state_nxt  = dtq_pkg::ST_FIRE;
        end
      end
      dtq_pkg::ST_FIRE: begin
        if (!stat.pend || stat.slot_free) begin
          cmd.do_fire = 1'b1;
          chain_nxt   = 1'b1;
          state_nxt   = dtq_pkg::ST_LOAD;
        end
      end
      dtq_pkg::ST_FLUSH: begin
        if (stat.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = dtq_pkg::OUT_FLUSH;
          state_nxt    = dtq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dtq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/dtq_dp.sv */
// ----------------------------------------------------------------------------
// dtq_dp
// Datapath of the timer queue: entry memory, head and count, units left,
// pending fired entry and the output register.
// ----------------------------------------------------------------------------
module dtq_dp #(
  parameter int DEPTH = dtq_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [dtq_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dtq_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  output logic [dtq_pkg::OUT_TUSER_W-1:0] out_tuser,
  input  dtq_pkg::dtq_cmd_t               cmd,
  output dtq_pkg::dtq_stat_t              stat
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW:0]   DEPTH_W  = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [dtq_pkg::ID_W-1:0]    ids_mem  [DEPTH];
  logic [dtq_pkg::DELAY_W-1:0] dlys_mem [DEPTH];

  logic [IW-1:0]                head_r;
  logic [CW-1:0]                count_r;
  logic [dtq_pkg::UNITS_W-1:0]  units_r;
  logic                         err_r;
  logic                         pend_r;
  logic [dtq_pkg::ID_W-1:0]     pend_id_r;
  logic [dtq_pkg::ID_W-1:0]     rd_id_r;
  logic [dtq_pkg::DELAY_W-1:0]  rd_dly_r;

  logic                         out_valid_r;
  logic [dtq_pkg::ID_W-1:0]     out_id_r;
  logic                         out_fv_r;
  logic                         out_last_r;
  logic                         out_err_r;

  logic [dtq_pkg::ID_W-1:0]     in_id;
  logic [dtq_pkg::DELAY_W-1:0]  in_delay;
  logic [dtq_pkg::UNITS_W-1:0]  in_units;
  logic                         full;
  logic                         append_ok;
  logic [CW:0]                  tail_sum;
  logic [IW-1:0]                tail;
  logic                         wr_en;
  logic [IW-1:0]                wr_addr;
  logic [dtq_pkg::DELAY_W-1:0]  wr_dly;
  logic                         slot_free;
  logic [IW-1:0]                head_inc;

  assign in_id    = in_tdata[7:0];
  assign in_delay = in_tdata[39:8];
  assign in_units = in_tdata[71:40];

  assign full      = (count_r == FULL_CNT);
  assign append_ok = cmd.load_in && (in_tuser == dtq_pkg::OP_APPEND) && !full;

  assign tail_sum = (CW + 1)'(head_r) + (CW + 1)'(count_r);
  assign tail     = (tail_sum >= DEPTH_W) ? IW'(tail_sum - DEPTH_W) : IW'(tail_sum);
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;

  assign wr_en   = append_ok || cmd.do_reduce;
  assign wr_addr = cmd.do_reduce ? head_r : tail;
  assign wr_dly  = cmd.do_reduce ? (rd_dly_r - units_r) : in_delay;

  assign slot_free = !out_valid_r || out_tready;

  // entry memory: one write port, one registered read at the head
  always_ff @(posedge clk) begin
    if (wr_en) begin
      dlys_mem[wr_addr] <= wr_dly;
    end
    if (append_ok) begin
      ids_mem[wr_addr] <= in_id;
    end
    rd_id_r  <= ids_mem[head_r];
    rd_dly_r <= dlys_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (append_ok) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.do_fire) begin
        count_r <= count_r - 1'b1;
        head_r  <= head_inc;
      end
      if (cmd.load_in) begin
        pend_r <= 1'b0;
      end else if (cmd.do_fire) begin
        pend_r <= 1'b1;
      end
      if ((cmd.do_fire && pend_r) || cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      units_r <= in_units;
      err_r   <= full;
    end else if (cmd.do_sub) begin
      units_r <= units_r - rd_dly_r;
    end
    if (cmd.do_fire) begin
      pend_id_r <= rd_id_r;
    end
    if (cmd.do_fire && pend_r) begin
      out_id_r   <= pend_id_r;
      out_fv_r   <= 1'b1;
      out_last_r <= 1'b0;
      out_err_r  <= 1'b0;
    end else if (cmd.out_load) begin
      case (cmd.out_kind)
        dtq_pkg::OUT_APPEND: begin
          out_id_r   <= '0;
          out_fv_r   <= 1'b0;
          out_last_r <= 1'b1;
          out_err_r  <= err_r;
        end
        default: begin
          out_id_r   <= pend_r ? pend_id_r : '0;
          out_fv_r   <= pend_r;
          out_last_r <= 1'b1;
          out_err_r  <= 1'b0;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_id_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_err_r, out_fv_r};

  always_comb begin
    stat.in_op       = in_tuser;
    stat.slot_free   = slot_free;
    stat.pend        = pend_r;
    stat.count_zero  = (count_r == '0);
    stat.units_zero  = (units_r == '0);
    stat.rd_dly_zero = (rd_dly_r == '0);
    stat.units_lt    = (units_r < rd_dly_r);
  end

endmodule

/* rtl/delta_timer_queue_advance.sv */
// ----------------------------------------------------------------------------
// delta_timer_queue_advance
// Delta-list timer queue with append and advance requests.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH timers in arrival order, each with a delay
// relative to the one before it. One request is handled at a time. An append
// goes from the append state back to idle and loads its status result into
// the output register as it leaves. An advance goes through the load and
// check states, then through fire, load and check once per fired entry, and
// ends in the flush state, which loads its final result, whether the head is
// only reduced or not touched. The per-entry cost comes from the single
// registered read port of the entry memory, which must reload the new head
// after every pop. Stalls on the result channel hold the append, fire and
// flush states. No clearing pass: entries are read only after being written.
module delta_timer_queue_advance #(
  parameter int DEPTH = dtq_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [dtq_pkg::IN_TDATA_W-1:0]  in_tdata,   // timer_id[7:0], delay[39:8], units[71:40]
  input  logic                            in_tuser,   // op
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dtq_pkg::OUT_TDATA_W-1:0] out_tdata,  // fired_id[7:0]
  output logic                            out_tlast,
  output logic [dtq_pkg::OUT_TUSER_W-1:0] out_tuser   // fired_valid[0], full_error[1]
);

  dtq_pkg::dtq_cmd_t  cmd;
  dtq_pkg::dtq_stat_t stat;

  dtq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dtq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

/* rtl/dtq_checker.sv */
// ----------------------------------------------------------------------------
// dtq_port_checks
// Port-level checks of the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module dtq_port_checks (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [dtq_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast,
  input logic [dtq_pkg::OUT_TUSER_W-1:0] out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a dropped append is a lone status result
  a_err_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast && !out_tuser[0])
    else $error("full error on a fired or non-final result");

  // a result without a fired timer closes its request
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && (out_tdata == '0))
    else $error("empty result not final or id not zero");

  // one request at a time: an accepted request holds off the next one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after an accepted request");

endmodule

bind delta_timer_queue_advance dtq_port_checks u_dtq_port_checks (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
